[src/dtac_pkg.sv]
// Shared types and constants for the double 3-AP checker.
package dtac_pkg;

    localparam int VALUE_W     = 32;
    localparam int LEN_W       = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_APPEND = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the incoming request
        logic exec;    // clear / append / full check
        logic setup;   // init scan indices
        logic issue;   // read pair (i, mid), step indices
        logic finish;  // build result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic skip;        // clear, or fewer than three elements
        logic last_issue;  // current issue is the final pair
        logic out_free;    // output register can take a result
    } t_dp_stat;

endpackage

[src/dtac_ctrl.sv]
// Controller state machine for the double 3-AP checker.
module dtac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  dtac_pkg::t_dp_stat i_stat,
    output logic              o_req_ready,
    output dtac_pkg::t_dp_cmd  o_cmd
);
    import dtac_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETUP,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_req_valid;
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_SETUP;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.skip ? ST_DONE : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.last_issue) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // last read pair is compared here
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);

endmodule

[src/dtac_dp.sv]
// Datapath: sequence memory, scan indices, compare and result register.
module dtac_dp #(
    parameter int MAX_LEN = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dtac_pkg::t_dp_cmd                   i_cmd,
    output dtac_pkg::t_dp_stat                  o_stat,
    input  logic                                i_op,
    input  logic [dtac_pkg::VALUE_W-1:0]        i_value,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_wr_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dtac_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import dtac_pkg::*;

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int EXT_W = (CW > LEN_W) ? CW : LEN_W;

    // request latch
    logic                      r_op;
    logic signed [VALUE_W-1:0] r_val;

    // sequence state
    logic signed [VALUE_W-1:0] r_mem [MAX_LEN];
    logic [CW-1:0]             r_count;
    logic signed [VALUE_W-1:0] r_last_val;
    logic                      r_full_err;
    logic                      r_sticky;
    logic                      r_check_all;

    // scan
    logic [AW:0]               r_idx_i;
    logic [AW-1:0]             r_idx_mid;
    logic [AW-1:0]             r_last_idx;
    logic signed [VALUE_W-1:0] r_rd_a;
    logic signed [VALUE_W-1:0] r_rd_m;
    logic                      r_rd_vld;
    logic                      r_hit;

    // result register
    logic                      r_out_vld;
    logic                      r_out_pass;
    logic [LEN_W-1:0]          r_out_len;
    logic                      r_out_full;

    logic                      is_full;
    logic                      mem_we;
    logic [CW-1:0]             count_m1;
    logic [AW-1:0]             last_idx;
    logic [AW:0]               mid_sum;
    logic [AW:0]               idx_i_next;
    logic signed [VALUE_W:0]   lhs;
    logic signed [VALUE_W:0]   rhs;
    logic                      match;
    logic                      sticky_n;
    logic [EXT_W-1:0]          len_ext;

    assign is_full    = (r_count == CW'(MAX_LEN));
    assign mem_we     = i_cmd.exec && (r_op == OP_APPEND) && !is_full;
    assign count_m1   = r_count - CW'(1);
    assign last_idx   = count_m1[AW-1:0];
    assign mid_sum    = {1'b0, last_idx} + (AW + 1)'(last_idx[0]);
    assign idx_i_next = r_idx_i + (AW + 1)'(2);

    // 2*x[mid] == x[i] + x[last], exact in 33 bits
    assign lhs   = {r_rd_m, 1'b0};
    assign rhs   = {r_rd_a[VALUE_W-1], r_rd_a} + {r_last_val[VALUE_W-1], r_last_val};
    assign match = r_rd_vld && (lhs == rhs);

    assign sticky_n = r_sticky | (r_hit & ~r_full_err);
    assign len_ext  = EXT_W'(r_count);

    assign o_stat.skip       = (r_op == OP_CLEAR) || (r_count < CW'(3));
    assign o_stat.last_issue = (idx_i_next >= {1'b0, r_last_idx});
    assign o_stat.out_free   = !r_out_vld || i_out_ready;

    // memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= r_val;
        end
        if (i_cmd.issue) begin
            r_rd_a <= r_mem[r_idx_i[AW-1:0]];
            r_rd_m <= r_mem[r_idx_mid];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_val <= i_value;
        end
        if (mem_we) begin
            r_last_val <= r_val;
        end
        if (i_cmd.setup) begin
            r_last_idx <= last_idx;
            r_idx_i    <= {{AW{1'b0}}, last_idx[0]};
            r_idx_mid  <= mid_sum[AW:1];
        end else if (i_cmd.issue) begin
            r_idx_i   <= idx_i_next;
            r_idx_mid <= r_idx_mid + AW'(1);
        end
        if (i_cmd.finish) begin
            r_out_pass <= r_check_all ? ~sticky_n : ~r_hit;
            r_out_len  <= len_ext[LEN_W-1:0];
            r_out_full <= r_full_err;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_full_err  <= 1'b0;
            r_sticky    <= 1'b0;
            r_check_all <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_check_all <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                if (r_op == OP_CLEAR) begin
                    r_count    <= '0;
                    r_sticky   <= 1'b0;
                    r_full_err <= 1'b0;
                end else if (is_full) begin
                    r_full_err <= 1'b1;
                end else begin
                    r_count    <= r_count + CW'(1);
                    r_full_err <= 1'b0;
                end
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.setup) begin
                r_hit <= 1'b0;
            end else if (match) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_sticky  <= sticky_n;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {{(OUT_TDATA_W - LEN_W - 2){1'b0}}, r_out_full, r_out_len, r_out_pass};

endmodule

[src/double_three_ap_checker.sv]
// Top level of the double 3-AP checker: controller, datapath and checks.
//
// Usage: each request on the slave stream is one operation. tuser = 0 clears
// the stored sequence, tuser = 1 appends tdata (32-bit two's complement).
// Every request yields exactly one result on the master stream: pass,
// length (stored count, low 8 bits) and full_error.
// check_all (cfg write port) selects what pass covers: 0 = only the
// triples ending at the newest element, 1 = every triple since the last
// clear (sticky). Write it only while the block is idle.
// After the accepting edge the controller steps through EXEC and SETUP; a clear
// or a sequence shorter than three then goes to DONE, else SCAN and FLUSH come
// first. The scan reads one (i, mid) pair per cycle from the two read ports of
// the sequence memory.
// One request is in flight at a time; tready is high in idle.
// The result sits in an output register, so the next request is taken while
// the receiver stalls; a further result waits in the controller until the
// register drains.
// Reset (synchronous, active low) empties the sequence, clears the sticky
// flag and check_all, and drops any pending result. No clearing pass.
module double_three_ap_checker #(
    parameter int MAX_LEN = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [dtac_pkg::VALUE_W-1:0]     i_s_axis_tdata,  // [31:0] value
    input  logic                             i_s_axis_tuser,  // [0] operation
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [dtac_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,  // [0] pass, [8:1] length,
                                                              // [9] full_error, [15:10] zero
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_wr_data    // check_all
);
    import dtac_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     s_accept;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    dtac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_stat      (stat),
        .o_req_ready (o_s_axis_tready),
        .o_cmd       (cmd)
    );

    dtac_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_s_axis_tuser),
        .i_value       (i_s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata)
    );

    // one request in flight: no accept right after an accept
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("request accepted while previous one is in flight");

    // a dropped append only happens with a full store
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[9]) |->
            (o_m_axis_tdata[8:1] == LEN_W'(MAX_LEN)))
        else $error("full_error reported with length below MAX_LEN");

    // reported length never exceeds the store size
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((MAX_LEN > 255) || (int'(o_m_axis_tdata[8:1]) <= MAX_LEN)))
        else $error("reported length exceeds MAX_LEN");

endmodule
